// ===== src/dvw_pkg.sv =====
// shared types, constants and functions for the date-time check and weekday pipeline
package dvw_pkg;

    localparam int unsigned YEAR_W = 12;
    localparam int unsigned SUM_W  = 12;

    localparam logic [YEAR_W-1:0] YEAR_BASE  = 12'd2000;
    localparam logic [YEAR_W-1:0] YEAR_2100  = 12'd2100;
    localparam logic [YEAR_W-1:0] YEAR_2200  = 12'd2200;

    localparam logic [7:0] HOUR_MAX   = 8'd23;
    localparam logic [7:0] MINUTE_MAX = 8'd59;
    localparam logic [7:0] SECOND_MAX = 8'd59;
    localparam logic [7:0] MONTH_MIN  = 8'd1;
    localparam logic [7:0] MONTH_MAX  = 8'd12;
    localparam logic [7:0] MONTH_MAR  = 8'd3;

    // offsets from 2000 of the two century years in range that are not leap years
    localparam logic [7:0] OFS_2100 = 8'd100;
    localparam logic [7:0] OFS_2200 = 8'd200;

    localparam logic [4:0] Q100_19 = 5'd19;
    localparam logic [4:0] Q100_20 = 5'd20;
    localparam logic [4:0] Q100_21 = 5'd21;
    localparam logic [4:0] Q100_22 = 5'd22;
    localparam logic [2:0] Q400_4  = 3'd4;
    localparam logic [2:0] Q400_5  = 3'd5;

    localparam logic [2:0] WEEKDAY_NONE = 3'd0;

    typedef struct packed {
        logic [7:0] year_offset;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } t_dvw_in;

    typedef struct packed {
        logic       status;
        logic [2:0] weekday;
    } t_dvw_out;

    typedef struct packed {
        logic              ok;
        logic [YEAR_W-1:0] year;
        logic [2:0]        shift;
        logic [4:0]        day;
    } t_dvw_s1;

    typedef struct packed {
        logic              ok;
        logic [YEAR_W-1:0] year;
        logic [YEAR_W-3:0] q4;
        logic [4:0]        q100;
        logic [2:0]        q400;
        logic [5:0]        md;
    } t_dvw_s2;

    typedef struct packed {
        logic             ok;
        logic [SUM_W-1:0] sum;
    } t_dvw_s3;

    function automatic logic [2:0] month_shift(input logic [3:0] mo);
        logic [2:0] r;
        unique case (mo)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] r;
        unique case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
            4'd2:    r = leap ? 5'd29 : 5'd28;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // 8 is 1 mod 7, so octal digits fold before a short reduction
    function automatic logic [2:0] mod7(input logic [SUM_W-1:0] s);
        logic [4:0] d;
        logic [4:0] r;
        d = 5'({2'b0, s[2:0]} + {2'b0, s[5:3]} + {2'b0, s[8:6]} + {2'b0, s[11:9]});
        priority if (d >= 5'd21) begin
            r = d - 5'd21;
        end else if (d >= 5'd14) begin
            r = d - 5'd14;
        end else if (d >= 5'd7) begin
            r = d - 5'd7;
        end else begin
            r = d;
        end
        return r[2:0];
    endfunction

endpackage

// ===== src/datetime_validate_weekday.sv =====
// top level: date-time validation with weekday, four-stage pipeline
// an input transfer reaches the result through the check, terms, sum and weekday stage registers
// throughput: one item per cycle while i_ready does not stall the output; each of the four stages holds one item
// a stage takes a new item when it is empty or its result moves on
// reset: synchronous active-low i_rst_n clears all stage valid bits
module datetime_validate_weekday (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dvw_pkg::t_dvw_in  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output dvw_pkg::t_dvw_out o_data
);
    import dvw_pkg::*;

    logic    s1_valid;
    logic    s1_ready;
    t_dvw_s1 s1_data;
    logic    s2_valid;
    logic    s2_ready;
    t_dvw_s2 s2_data;
    logic    s3_valid;
    logic    s3_ready;
    t_dvw_s3 s3_data;

    dvw_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    dvw_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    dvw_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    dvw_wday u_wday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_data  (s3_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    a_err_weekday_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status |-> o_data.weekday == WEEKDAY_NONE)
        else $error("error result carries a nonzero weekday");

    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.weekday != 3'd7)
        else $error("weekday out of range");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result lost or changed");

endmodule

// ===== src/dvw_check.sv =====
// stage 1: range checks, month length, adjusted year and month shift
module dvw_check (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dvw_pkg::t_dvw_in i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output dvw_pkg::t_dvw_s1 o_data
);
    import dvw_pkg::*;

    logic    r_valid;
    t_dvw_s1 r_data;
    t_dvw_s1 n_data;
    logic    time_ok;
    logic    mon_ok;
    logic    day_ok;
    logic    leap;
    logic    early;
    logic [4:0] len;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        time_ok = (i_data.hour <= HOUR_MAX) && (i_data.minute <= MINUTE_MAX)
                  && (i_data.second <= SECOND_MAX);
        mon_ok  = (i_data.month >= MONTH_MIN) && (i_data.month <= MONTH_MAX);
        leap    = (i_data.year_offset[1:0] == 2'b00) && (i_data.year_offset != OFS_2100)
                  && (i_data.year_offset != OFS_2200);
        len     = month_len(i_data.month[3:0], leap);
        day_ok  = (i_data.day != 8'd0) && (i_data.day <= {3'b000, len});
        early   = i_data.month < MONTH_MAR;
        n_data.ok    = time_ok && mon_ok && day_ok;
        n_data.year  = YEAR_BASE + {4'b0000, i_data.year_offset} - {11'b0, early};
        n_data.shift = month_shift(i_data.month[3:0]);
        n_data.day   = i_data.day[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/dvw_terms.sv =====
// stage 2: century and leap correction terms and the month-day term of the weekday sum
module dvw_terms (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dvw_pkg::t_dvw_s1 i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output dvw_pkg::t_dvw_s2 o_data
);
    import dvw_pkg::*;

    logic    r_valid;
    t_dvw_s2 r_data;
    t_dvw_s2 n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.ok   = i_data.ok;
        n_data.year = i_data.year;
        n_data.q4   = i_data.year[YEAR_W-1:2];
        priority if (i_data.year < YEAR_BASE) begin
            n_data.q100 = Q100_19;
        end else if (i_data.year < YEAR_2100) begin
            n_data.q100 = Q100_20;
        end else if (i_data.year < YEAR_2200) begin
            n_data.q100 = Q100_21;
        end else begin
            n_data.q100 = Q100_22;
        end
        n_data.q400 = (i_data.year < YEAR_BASE) ? Q400_4 : Q400_5;
        n_data.md   = {3'b000, i_data.shift} + {1'b0, i_data.day};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/dvw_sum.sv =====
// stage 3: weekday sum before reduction
module dvw_sum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dvw_pkg::t_dvw_s2 i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output dvw_pkg::t_dvw_s3 o_data
);
    import dvw_pkg::*;

    logic    r_valid;
    t_dvw_s3 r_data;
    t_dvw_s3 n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.ok  = i_data.ok;
        n_data.sum = i_data.year + {2'b00, i_data.q4} + {9'b0, i_data.q400}
                     + {6'b0, i_data.md} - {7'b0, i_data.q100};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/dvw_wday.sv =====
// stage 4: modulo-7 reduction and result register
module dvw_wday (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dvw_pkg::t_dvw_s3  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output dvw_pkg::t_dvw_out o_data
);
    import dvw_pkg::*;

    logic     r_valid;
    t_dvw_out r_data;
    t_dvw_out n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.status  = !i_data.ok;
        n_data.weekday = i_data.ok ? mod7(i_data.sum) : WEEKDAY_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
